// File: rtl/core/lrq_pkg.sv
// ----------------------------------------------------------------------------
// lrq_pkg
// Shared codes, characters and stream field layout for the line receive queue.
// ----------------------------------------------------------------------------
package lrq_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] FUNC_RX_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_RX_ERROR = 2'd1;
    localparam logic [1:0] FUNC_READ     = 2'd2;

    // Line terminators.
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Field widths and bit positions on the stream ports.
    localparam int FUNC_W = 2;
    localparam int BYTE_W = 8;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    localparam int M_USER_FOUND = 0;
    localparam int M_USER_VALID = 1;

endpackage

// File: rtl/core/line_receive_queue.sv
// ----------------------------------------------------------------------------
// line_receive_queue
// Assembles received bytes into text lines and queues finished lines.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one operation per transaction, selected by s_tuser:
// a received byte (s_tdata[7:0]), a receive error, or a request to read one
// line with the reader's buffer size in s_tdata[15:8]. A CR or LF byte closes
// a non-empty line and queues it; if the queue is full the line is dropped.
// A receive error discards the line being built.
// A read pops the oldest line and sends its characters on the output stream,
// one per transaction, at most read_limit-1 of them, with m_tlast on the
// final one. An empty queue, or a limit that allows no characters, yields a
// single transaction with char_valid low and m_tlast high.
// Throughput: byte and error transactions are accepted one per cycle while
// the block is idle. A read is accepted, its length is looked up in the length
// memory, and then its characters follow one per cycle unless m_tready stalls,
// paced by the single read port of the character memory.
// While a read is in progress s_tready stays low. A stall on m_tready holds
// the output register and the character walk; nothing is lost.
// Reset clears the build length, the queue pointers and the line count; the
// memories need no clearing since an entry is read only after being written.
// ----------------------------------------------------------------------------
module line_receive_queue
    import lrq_pkg::*;
#(
    parameter int LINE_LEN    = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_data, [15:8] read_limit
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] func
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] char_out
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] line_found, [1] char_valid
    output logic                 m_tlast
);

    // Offset bits within a slot, length bits, slot and count bits.
    localparam int OFF_W   = (LINE_LEN > 2) ? $clog2(LINE_LEN - 1) : 1;
    localparam int LEN_W   = $clog2(LINE_LEN);
    localparam int SLOT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int NSLOT   = QUEUE_DEPTH + 1;
    localparam int ADDR_W  = SLOT_W + OFF_W;
    localparam int MEM_DEPTH = NSLOT * (2 ** OFF_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LEN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // The line store holds one slot more than the queue depth. The line
    // under construction is written straight into the slot at the write
    // pointer, which is never one of the queued slots, so a finished line
    // is queued by moving the pointer instead of copying characters.
    logic [BYTE_W-1:0] char_mem [MEM_DEPTH];
    logic [LEN_W-1:0]  len_mem  [NSLOT];

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    build_len_reg, build_len_next;
    logic [SLOT_W-1:0]   wslot_reg, wslot_next;
    logic [SLOT_W-1:0]   rslot_reg, rslot_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0]   held_reg, held_next;
    logic                found_reg, found_next;
    logic [BYTE_W-1:0]   cap_reg, cap_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [OFF_W-1:0]    idx_reg, idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_char_reg, out_char_next;
    logic                out_found_reg, out_found_next;
    logic                out_cvalid_reg, out_cvalid_next;
    logic                out_last_reg, out_last_next;

    // Memory ports.
    logic                char_wr_en;
    logic [ADDR_W-1:0]   char_wr_addr;
    logic [BYTE_W-1:0]   char_wr_data;
    logic                char_rd_en;
    logic [ADDR_W-1:0]   char_rd_addr;
    logic [BYTE_W-1:0]   char_q;
    logic                len_wr_en;
    logic                len_rd_en;
    logic [LEN_W-1:0]    len_q;

    logic [FUNC_W-1:0]   in_func;
    logic [BYTE_W-1:0]   in_byte;
    logic [BYTE_W-1:0]   in_limit;
    logic                in_accept;
    logic                out_free;
    logic                is_term;
    logic [LEN_W-1:0]    eff_len;
    logic                emit_last;

    assign in_func   = s_tuser[FUNC_W-1:0];
    assign in_byte   = s_tdata[BYTE_W-1:0];
    assign in_limit  = s_tdata[2*BYTE_W-1:BYTE_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign is_term   = (in_byte == CHAR_LF) || (in_byte == CHAR_CR);

    // Popped length limited by the reader's buffer size.
    always_comb begin
        if (!found_reg) begin
            eff_len = '0;
        end else if (BYTE_W'(len_q) > cap_reg) begin
            eff_len = cap_reg[LEN_W-1:0];
        end else begin
            eff_len = len_q;
        end
    end

    assign emit_last = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(NSLOT - 1)) begin
            return '0;
        end
        return s + SLOT_W'(1);
    endfunction

    always_comb begin
        state_next      = state_reg;
        build_len_next  = build_len_reg;
        wslot_next      = wslot_reg;
        rslot_next      = rslot_reg;
        cur_slot_next   = cur_slot_reg;
        held_next       = held_reg;
        found_next      = found_reg;
        cap_next        = cap_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_found_next  = out_found_reg;
        out_cvalid_next = out_cvalid_reg;
        out_last_next   = out_last_reg;
        char_wr_en      = 1'b0;
        char_wr_addr    = {wslot_reg, build_len_reg[OFF_W-1:0]};
        char_wr_data    = in_byte;
        char_rd_en      = 1'b0;
        char_rd_addr    = {cur_slot_reg, idx_reg};
        len_wr_en       = 1'b0;
        len_rd_en       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_func)
                        FUNC_RX_BYTE: begin
                            if (is_term) begin
                                if (build_len_reg != '0) begin
                                    if (held_reg < SLOT_W'(QUEUE_DEPTH)) begin
                                        len_wr_en  = 1'b1;
                                        wslot_next = slot_inc(wslot_reg);
                                        held_next  = held_reg + SLOT_W'(1);
                                    end
                                    build_len_next = '0;
                                end
                            end else if (build_len_reg < LEN_W'(LINE_LEN - 1)) begin
                                char_wr_en     = 1'b1;
                                build_len_next = build_len_reg + LEN_W'(1);
                            end
                        end
                        FUNC_RX_ERROR: begin
                            build_len_next = '0;
                        end
                        FUNC_READ: begin
                            cap_next   = (in_limit == '0) ? '0 : in_limit - BYTE_W'(1);
                            state_next = ST_LEN;
                            if (held_reg != '0) begin
                                len_rd_en     = 1'b1;
                                found_next    = 1'b1;
                                cur_slot_next = rslot_reg;
                                rslot_next    = slot_inc(rslot_reg);
                                held_next     = held_reg - SLOT_W'(1);
                            end else begin
                                found_next = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LEN: begin
                if (eff_len == '0) begin
                    // No characters to send: a single closing transaction.
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_char_next   = '0;
                        out_found_next  = found_reg;
                        out_cvalid_next = 1'b0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    char_rd_en   = 1'b1;
                    char_rd_addr = {cur_slot_reg, {OFF_W{1'b0}}};
                    len_next     = eff_len;
                    idx_next     = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // char_q holds the character at idx_reg.
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_char_next   = char_q;
                    out_found_next  = 1'b1;
                    out_cvalid_next = 1'b1;
                    out_last_next   = emit_last;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next     = idx_reg + OFF_W'(1);
                        char_rd_en   = 1'b1;
                        char_rd_addr = {cur_slot_reg, idx_reg + OFF_W'(1)};
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Character and length memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (char_wr_en) begin
            char_mem[char_wr_addr] <= char_wr_data;
        end
        if (char_rd_en) begin
            char_q <= char_mem[char_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (len_wr_en) begin
            len_mem[wslot_reg] <= build_len_reg;
        end
        if (len_rd_en) begin
            len_q <= len_mem[rslot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            build_len_reg <= '0;
            wslot_reg     <= '0;
            rslot_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            build_len_reg <= build_len_next;
            wslot_reg     <= wslot_next;
            rslot_reg     <= rslot_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_slot_reg   <= cur_slot_next;
        found_reg      <= found_next;
        cap_reg        <= cap_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        out_char_reg   <= out_char_next;
        out_found_reg  <= out_found_next;
        out_cvalid_reg <= out_cvalid_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid              = out_valid_reg;
    assign m_tdata               = out_char_reg;
    assign m_tuser[M_USER_FOUND] = out_found_reg;
    assign m_tuser[M_USER_VALID] = out_cvalid_reg;
    assign m_tlast               = out_last_reg;

endmodule

// File: rtl/core/lrq_checker.sv
// ----------------------------------------------------------------------------
// lrq_checker
// Port-level checks for the line receive queue, bound to the top level.
// ----------------------------------------------------------------------------
module lrq_checker
    import lrq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    // No result transaction is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A stalled result transaction holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // A result without a character always closes the read with a zero byte.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[M_USER_VALID] |-> m_tlast && (m_tdata == '0))
        else $error("result without character is not final");

    // An empty-queue answer carries no character.
    a_notfound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[M_USER_FOUND] |-> !m_tuser[M_USER_VALID])
        else $error("character sent without a line");

    // The input side is held off while a line is still being sent.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during a line read");

endmodule

bind line_receive_queue lrq_checker u_lrq_checker (.*);

// File: tb/sv/line_receive_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_receive_queue_tb
// Self-checking bench for the line receive queue. Received bytes, receive
// errors and read requests are streamed into the block. Each accepted
// transaction also goes to a scoreboard that keeps its own copy of the line
// being built and of the queued lines, and works out the characters that
// every read must return. Those characters are compared field by field with
// the result stream. The run goes through several handshake pressure
// settings on both sides.
// ----------------------------------------------------------------------------
module line_receive_queue_tb;
    import lrq_pkg::*;

    localparam int LINE_LEN    = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int LINE_CHARS  = LINE_LEN - 1;

    localparam int CLK_HALF       = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PRINTED    = 30;
    localparam int PHASE_ITEMS    = 88;

    // The operation code that the block must ignore.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [7:0] LIMIT_MAX   = 8'd255;

    // One result transaction, as the result stream presents it.
    typedef struct packed {
        logic       found;
        logic [7:0] char_out;
        logic       char_valid;
        logic       is_last;
    } char_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It tracks the line being built and the queue of finished
    // lines, and turns each accepted read into the characters it must return.
    // ------------------------------------------------------------------------
    class line_queue_scoreboard;
        logic [7:0]   line_build [LINE_CHARS];
        int unsigned  build_len;
        logic [7:0]   queued_text [QUEUE_DEPTH][LINE_CHARS];
        int unsigned  queued_len [QUEUE_DEPTH];
        int unsigned  head_slot;
        int unsigned  tail_slot;
        int unsigned  lines_held;
        char_result_t expected_chars [$];

        int unsigned  mismatches;
        int unsigned  results_checked;
        int unsigned  lines_stored;
        int unsigned  lines_dropped;
        int unsigned  lines_read;
        int unsigned  empty_reads;

        function new();
            build_len       = 0;
            head_slot       = 0;
            tail_slot       = 0;
            lines_held      = 0;
            mismatches      = 0;
            results_checked = 0;
            lines_stored    = 0;
            lines_dropped   = 0;
            lines_read      = 0;
            empty_reads     = 0;
        endfunction

        function int unsigned outstanding();
            return expected_chars.size();
        endfunction

        // Applies one accepted input transaction to the tracked state.
        function void note_transaction(logic [1:0] func, logic [7:0] rx_byte,
                                       logic [7:0] read_limit);
            int unsigned  take;
            char_result_t res;
            case (func)
                FUNC_RX_BYTE: begin
                    if (rx_byte == CHAR_LF || rx_byte == CHAR_CR) begin
                        // A terminator closes the line only if it holds something.
                        if (build_len != 0) begin
                            if (lines_held < QUEUE_DEPTH) begin
                                for (int i = 0; i < build_len; i++)
                                    queued_text[tail_slot][i] = line_build[i];
                                queued_len[tail_slot] = build_len;
                                tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
                                lines_held++;
                                lines_stored++;
                            end else begin
                                lines_dropped++;
                            end
                            build_len = 0;
                        end
                    end else if (build_len < LINE_CHARS) begin
                        line_build[build_len] = rx_byte;
                        build_len++;
                    end
                end
                FUNC_RX_ERROR: begin
                    build_len = 0;
                end
                FUNC_READ: begin
                    res         = '0;
                    res.is_last = 1'b1;
                    if (lines_held == 0) begin
                        empty_reads++;
                        expected_chars.push_back(res);
                    end else begin
                        take = queued_len[head_slot];
                        if (read_limit == 0)
                            take = 0;
                        else if (take > read_limit - 1)
                            take = read_limit - 1;
                        res.found = 1'b1;
                        if (take == 0) begin
                            expected_chars.push_back(res);
                        end else begin
                            for (int i = 0; i < take; i++) begin
                                res.char_out   = queued_text[head_slot][i];
                                res.char_valid = 1'b1;
                                res.is_last    = (i == take - 1);
                                expected_chars.push_back(res);
                            end
                        end
                        head_slot = (head_slot + 1) % QUEUE_DEPTH;
                        lines_held--;
                        lines_read++;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Compares one accepted result transaction with the oldest expectation.
        task check_result(char_result_t got);
            char_result_t want;
            if (expected_chars.size() == 0) begin
                report($sformatf("result transaction with nothing expected (char 0x%02h)",
                                 got.char_out));
                return;
            end
            want = expected_chars.pop_front();
            results_checked++;
            if (got.found !== want.found)
                report($sformatf("line_found %b, expected %b", got.found, want.found));
            if (got.char_out !== want.char_out)
                report($sformatf("char_out 0x%02h, expected 0x%02h",
                                 got.char_out, want.char_out));
            if (got.char_valid !== want.char_valid)
                report($sformatf("char_valid %b, expected %b",
                                 got.char_valid, want.char_valid));
            if (got.is_last !== want.is_last)
                report($sformatf("tlast %b, expected %b", got.is_last, want.is_last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the stream signals. All inputs start at known values.
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [7:0] rx_data, [15:8] read_limit
    logic [1:0]  s_tuser  = '0;     // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] char_out
    logic [1:0]  m_tuser;           // [0] line_found, [1] char_valid
    logic        m_tlast;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    // Input transactions sent so far, leaving out ignored operation codes.
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;

    line_queue_scoreboard sb;

    always #CLK_HALF aclk = ~aclk;

    line_receive_queue #(
        .LINE_LEN    (LINE_LEN),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The receiver decides afresh every cycle whether it takes a result, so
    // stalls land on the first character, the middle and the end of a read.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= stall_pct);
    end

    // Both handshakes are sampled at the rising edge, where the inputs driven
    // at the falling edge are stable. The watchdog counts edges at which no
    // transaction is accepted on either side.
    always @(posedge aclk) begin
        char_result_t got;
        bit           moved;
        if (aresetn) begin
            moved = 1'b0;
            if (s_tvalid && s_tready === 1'b1) begin
                sb.note_transaction(s_tuser, s_tdata[BYTE_W-1:0],
                                    s_tdata[2*BYTE_W-1:BYTE_W]);
                moved = 1'b1;
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                got.found      = m_tuser[M_USER_FOUND];
                got.char_out   = m_tdata;
                got.char_valid = m_tuser[M_USER_VALID];
                got.is_last    = m_tlast;
                sb.check_result(got);
                moved = 1'b1;
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                             quiet_cycles, sb.outstanding());
                    $display("line_receive_queue_tb failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks. Inputs change only at the falling edge. A transaction
    // leaves tvalid high; the next call either replaces the data at once or
    // drops tvalid for a few idle cycles first.
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [1:0] func, input logic [7:0] rx_byte,
                           input logic [7:0] read_limit);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {read_limit, rx_byte};
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        if (func != FUNC_UNUSED)
            items_sent++;
    endtask

    // The field that an operation does not use carries random bits.
    task automatic send_byte(input logic [7:0] rx_byte);
        send_op(FUNC_RX_BYTE, rx_byte, 8'($urandom_range(255)));
    endtask

    task automatic send_error();
        send_op(FUNC_RX_ERROR, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic read_line(input logic [7:0] read_limit);
        send_op(FUNC_READ, 8'($urandom_range(255)), read_limit);
    endtask

    // Text content: anything but a terminator, with zero bytes made common.
    function automatic logic [7:0] line_char();
        logic [7:0] c;
        if ($urandom_range(9) == 0)
            return 8'h00;
        do
            c = 8'($urandom_range(255));
        while (c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    task automatic send_chars(input int unsigned count);
        repeat (count) send_byte(line_char());
    endtask

    // Mostly a full buffer, often a few characters, sometimes anything.
    function automatic logic [7:0] random_limit();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return LIMIT_MAX;
        if (pick < 75)
            return 8'($urandom_range(4));
        return 8'($urandom_range(255));
    endfunction

    // Directed cases: the empty queue, the ignored code, a zero byte inside a
    // line, an empty line, an error in mid-line, a full queue that drops a
    // line, and limits that truncate a line or allow no characters at all.
    task automatic run_directed();
        read_line(LIMIT_MAX);
        send_op(FUNC_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'h78);
        send_error();
        send_byte(8'h7A);
        send_byte(CHAR_LF);
        read_line(LIMIT_MAX);
        read_line(LIMIT_MAX);
        // Five lines into four slots: the last one is lost.
        send_chars(3);
        send_byte(CHAR_CR);
        repeat (4) begin
            send_chars(1);
            send_byte(CHAR_LF);
        end
        read_line(8'd2);
        read_line(8'd1);
        read_line(8'd0);
        read_line(LIMIT_MAX);
        read_line(LIMIT_MAX);
    endtask

    // Random traffic, mostly well-formed lines and reads, with broken lines,
    // stray bytes, errors and ignored codes mixed in.
    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  term;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            term = $urandom_range(1) ? CHAR_CR : CHAR_LF;
            if (pick < 42) begin
                // An occasional long line of up to 70 characters can overflow the build buffer.
                len = ($urandom_range(11) == 0) ? $urandom_range(55, 70)
                                                : $urandom_range(1, 8);
                if ($urandom_range(9) == 0) begin
                    send_chars($urandom_range(1, 4));
                    send_error();
                end
                send_chars(len);
                send_byte(term);
            end else if (pick < 72) begin
                read_line(random_limit());
            end else if (pick < 82) begin
                repeat ($urandom_range(2, 5)) read_line(random_limit());
            end else if (pick < 90) begin
                send_byte(8'($urandom_range(255)));
            end else if (pick < 96) begin
                send_error();
            end else begin
                send_op(FUNC_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Full throughput on both sides.
        run_directed();
        run_random(PHASE_ITEMS);

        // Sender idles about half the time.
        idle_pct = 50;
        run_random(PHASE_ITEMS);

        // Receiver stalls about half the time.
        idle_pct  = 0;
        stall_pct = 50;
        run_random(PHASE_ITEMS);

        // Both sides hesitate.
        idle_pct  = 31;
        stall_pct = 31;
        run_random(PHASE_ITEMS);

        @(negedge aclk);
        s_tvalid = 1'b0;

        // A missing result leaves this loop to the watchdog.
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d inputs sent: %0d lines queued, %0d dropped, %0d read, %0d empty reads.",
                 items_sent, sb.lines_stored, sb.lines_dropped, sb.lines_read,
                 sb.empty_reads);
        $display("Checked %0d results under four handshake settings, %0d mismatches.",
                 sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("line_receive_queue_tb passed");
        end else begin
            $display("line_receive_queue_tb failed");
        end
        $finish;
    end

endmodule
